// ===== sv/terminal_escape_stripper_unit_assert.svh =====
// assertion macros for the terminal escape stripper
// expects clk and arst_n in the scope of the including module
`ifndef TERMINAL_ESCAPE_STRIPPER_UNIT_ASSERT_SVH
`define TERMINAL_ESCAPE_STRIPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define TESU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("terminal escape stripper check failed");

// next-cycle implication
`define TESU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("terminal escape stripper check failed");

`endif

// ===== sv/tesu_pkg.sv =====
// shared constants and types for the terminal escape stripper
// no dependencies
package tesu_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int CAP_W       = 4;
	localparam int ADDR_W      = 3;

	typedef logic [LENGTH_BITS-1:0] count_t;
	typedef logic [LENGTH_BITS:0]   count_sum_t;

	// parser modes
	localparam logic [2:0] MODE_GROUND  = 3'd0;
	localparam logic [2:0] MODE_ESC     = 3'd1;
	localparam logic [2:0] MODE_CSI     = 3'd2;
	localparam logic [2:0] MODE_OSC     = 3'd3;
	localparam logic [2:0] MODE_OSC_ESC = 3'd4;

	// register index
	localparam logic REG_CURSOR_RIGHT_CAP = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	localparam logic [3:0] SPACE_LIMIT = 4'd8;
	localparam logic [3:0] NUM_MAX     = 4'd15;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_CUF    = 8'h43;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DEL    = 8'h7F;

endpackage

// ===== sv/terminal_escape_stripper_unit.sv =====
// Terminal escape stripper: one text byte in per item, printable text out.
// Throughput is one input item per cycle unless the output side stalls: the byte is
// registered, parsed in one pass against the parser state, and its result is
// placed in the output register. A cursor-right sequence that expands to n spaces
// holds the output register until all n spaces are taken, and the input side stalls
// once the parsed byte behind it also has a result to deliver. Bytes that give no result
// (dropped controls, escape bodies) never wait on the output side. Byte 0x00 ends
// the text, reports the number of bytes emitted and resets the parser.
// Depends on tesu_pkg and terminal_escape_stripper_unit_assert.svh.
`include "terminal_escape_stripper_unit_assert.svh"

module terminal_escape_stripper_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// apb configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tesu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       text_end,
	output logic [15:0]                out_length,
	output logic                       last
);

	// configuration
	logic [tesu_pkg::CAP_W-1:0] cap_q;
	logic                       cfg_wr;
	logic                       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_sel == tesu_pkg::REG_CURSOR_RIGHT_CAP) ? 32'(cap_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= tesu_pkg::CAP_RESET;
		end else if (cfg_wr && reg_sel == tesu_pkg::REG_CURSOR_RIGHT_CAP) begin
			cap_q <= pwdata[tesu_pkg::CAP_W-1:0];
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;

	// parser state
	logic [2:0]       mode_q;
	logic [3:0]       num_q;
	logic             has_digit_q;
	logic             seen_q;
	logic [1:0]       utf_q;
	tesu_pkg::count_t emit_cnt_q;

	logic [2:0] mode_d;
	logic [3:0] num_d;
	logic       has_digit_d;
	logic       seen_d;
	logic [1:0] utf_d;

	// result of the parsed byte
	logic [3:0] res_cnt;
	logic [7:0] res_byte;
	logic       res_end;
	logic       do_ground;

	logic [7:0] num_x10;
	logic [7:0] digit_v;
	logic [3:0] n_req;
	logic [3:0] n_cap;
	logic [3:0] n_sp;
	logic [31:0] cnt_ext;
	logic [15:0] len_clamp;
	tesu_pkg::count_sum_t cnt_sum;
	tesu_pkg::count_t     cnt_next;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       text_end_q;
	logic [15:0] out_length_q;
	logic [2:0] rep_q;
	logic       out_free;
	logic       out_fire;

	assign num_x10 = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0};
	assign digit_v = num_x10 + {4'b0000, byte_s1[3:0]};
	assign n_req   = has_digit_q ? num_q : 4'd1;
	assign n_cap   = (n_req > cap_q) ? cap_q : n_req;
	assign n_sp    = (n_cap > tesu_pkg::SPACE_LIMIT) ? tesu_pkg::SPACE_LIMIT : n_cap;

	assign cnt_ext   = 32'(emit_cnt_q);
	assign len_clamp = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];

	always_comb begin
		mode_d      = mode_q;
		num_d       = num_q;
		has_digit_d = has_digit_q;
		seen_d      = seen_q;
		utf_d       = utf_q;
		res_cnt     = 4'd0;
		res_byte    = byte_s1;
		res_end     = 1'b0;
		do_ground   = 1'b0;

		if (byte_s1 == tesu_pkg::CH_NUL) begin
			res_cnt     = 4'd1;
			res_end     = 1'b1;
			mode_d      = tesu_pkg::MODE_GROUND;
			num_d       = 4'd0;
			has_digit_d = 1'b0;
			seen_d      = 1'b0;
			utf_d       = 2'd0;
		end else begin
			unique case (mode_q)
				tesu_pkg::MODE_ESC: begin
					if (byte_s1 == tesu_pkg::CH_LBRACK) begin
						mode_d      = tesu_pkg::MODE_CSI;
						num_d       = 4'd0;
						has_digit_d = 1'b0;
						seen_d      = 1'b0;
					end else if (byte_s1 == tesu_pkg::CH_RBRACK) begin
						mode_d = tesu_pkg::MODE_OSC;
					end else if (byte_s1 >= 8'h20 && byte_s1 <= 8'h7E) begin
						mode_d = tesu_pkg::MODE_GROUND;
					end else begin
						// non-printable after esc is taken as a ground byte
						mode_d    = tesu_pkg::MODE_GROUND;
						do_ground = 1'b1;
					end
				end
				tesu_pkg::MODE_CSI: begin
					if (byte_s1 >= 8'h40 && byte_s1 <= 8'h7E) begin
						if (byte_s1 == tesu_pkg::CH_CUF && (has_digit_q || !seen_q)) begin
							res_cnt  = n_sp;
							res_byte = tesu_pkg::CH_SPACE;
						end
						mode_d = tesu_pkg::MODE_GROUND;
					end else begin
						seen_d = 1'b1;
						if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
							num_d       = (digit_v > 8'd15) ? tesu_pkg::NUM_MAX : digit_v[3:0];
							has_digit_d = 1'b1;
						end else if (byte_s1 == tesu_pkg::CH_SEMI) begin
							has_digit_d = 1'b0;
						end
					end
				end
				tesu_pkg::MODE_OSC, tesu_pkg::MODE_OSC_ESC: begin
					if (mode_q == tesu_pkg::MODE_OSC_ESC && byte_s1 == tesu_pkg::CH_BSLASH) begin
						mode_d = tesu_pkg::MODE_GROUND;
					end else if (byte_s1 == tesu_pkg::CH_BEL) begin
						mode_d = tesu_pkg::MODE_GROUND;
					end else if (byte_s1 == tesu_pkg::CH_ESC) begin
						mode_d = tesu_pkg::MODE_OSC_ESC;
					end else begin
						mode_d = tesu_pkg::MODE_OSC;
					end
				end
				default: begin
					mode_d    = tesu_pkg::MODE_GROUND;
					do_ground = 1'b1;
				end
			endcase

			if (do_ground) begin
				if (utf_q != 2'd0 && byte_s1[7:6] == 2'b10) begin
					utf_d   = utf_q - 2'd1;
					res_cnt = 4'd1;
				end else begin
					utf_d = 2'd0;
					if (byte_s1 == tesu_pkg::CH_ESC) begin
						mode_d = tesu_pkg::MODE_ESC;
					end else if ((byte_s1 < 8'h20 && byte_s1 != tesu_pkg::CH_LF &&
						byte_s1 != tesu_pkg::CH_TAB) || byte_s1 == tesu_pkg::CH_DEL) begin
						res_cnt = 4'd0;
					end else if (byte_s1 >= 8'hC2 && byte_s1 <= 8'hF4) begin
						// utf-8 lead byte opens a run of continuation bytes
						utf_d   = (byte_s1 <= 8'hDF) ? 2'd1 : (byte_s1 <= 8'hEF) ? 2'd2 : 2'd3;
						res_cnt = 4'd1;
					end else if (byte_s1 >= 8'h80 && byte_s1 <= 8'h9F) begin
						res_cnt = 4'd0;
					end else begin
						res_cnt = 4'd1;
					end
				end
			end
		end
	end

	// saturating emitted count
	assign cnt_sum  = {1'b0, emit_cnt_q} + (tesu_pkg::LENGTH_BITS+1)'(res_cnt);
	assign cnt_next = cnt_sum[tesu_pkg::LENGTH_BITS] ? '1 :
		cnt_sum[tesu_pkg::LENGTH_BITS-1:0];

	assign out_fire = out_valid_q && out_ready;
	assign out_free = !out_valid_q || (out_ready && rep_q == 3'd0);
	assign adv_s1   = valid_s1 && (res_cnt == 4'd0 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tesu_pkg::MODE_GROUND;
			num_q       <= 4'd0;
			has_digit_q <= 1'b0;
			seen_q      <= 1'b0;
			utf_q       <= 2'd0;
			emit_cnt_q  <= '0;
		end else if (adv_s1) begin
			mode_q      <= mode_d;
			num_q       <= num_d;
			has_digit_q <= has_digit_d;
			seen_q      <= seen_d;
			utf_q       <= utf_d;
			emit_cnt_q  <= res_end ? '0 : cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rep_q       <= 3'd0;
		end else if (adv_s1 && res_cnt != 4'd0) begin
			out_valid_q <= 1'b1;
			rep_q       <= 3'(res_cnt - 4'd1);
		end else if (out_fire) begin
			// a space burst repeats the same item until its count runs out
			if (rep_q != 3'd0) begin
				rep_q <= rep_q - 3'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_cnt != 4'd0) begin
			out_byte_q   <= res_end ? 8'h00 : res_byte;
			text_end_q   <= res_end;
			out_length_q <= res_end ? len_clamp : 16'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign text_end   = text_end_q;
	assign out_length = out_length_q;
	assign last       = (rep_q == 3'd0);

	`TESU_ASSERT_NOW(a_burst_is_spaces, out_valid_q && rep_q != 3'd0, out_byte_q == tesu_pkg::CH_SPACE && !text_end_q)
	`TESU_ASSERT_NOW(a_end_single, out_valid_q && text_end_q, rep_q == 3'd0 && out_byte_q == tesu_pkg::CH_NUL)
	`TESU_ASSERT_NEXT(a_burst_holds, out_fire && rep_q != 3'd0, out_valid_q && out_byte_q == $past(out_byte_q))
	`TESU_ASSERT_NEXT(a_end_clears, adv_s1 && byte_s1 == tesu_pkg::CH_NUL, mode_q == tesu_pkg::MODE_GROUND && emit_cnt_q == '0)
	`TESU_ASSERT_NOW(a_utf_in_ground, utf_q != 2'd0, mode_q == tesu_pkg::MODE_GROUND)

endmodule

// ===== tb/sv/terminal_escape_stripper_unit_tb.sv =====
// testbench for terminal_escape_stripper_unit: random and directed text streams with a
// checker class that predicts every kept, generated and end-of-text item
// depends on tesu_pkg and the unit itself

typedef struct packed {
	logic [7:0]       out_byte;
	logic             text_end;
	tesu_pkg::count_t out_length;
	logic             last;
} strip_result_t;

class stripped_text_checker;
	strip_result_t              awaited[$];
	int                         mismatches;
	int                         bytes_in;
	int                         results_out;
	int                         texts;
	int                         bursts;
	int                         longest;
	logic [tesu_pkg::CAP_W-1:0] cap;
	logic [2:0]                 mode;
	logic [3:0]                 number;
	bit                         has_digit;
	bit                         seen_byte;
	logic [1:0]                 utf8_left;
	tesu_pkg::count_t           emitted;

	function new();
		cap = tesu_pkg::CAP_RESET;
		clear_text();
	endfunction

	function void clear_text();
		mode = tesu_pkg::MODE_GROUND;
		number = '0;
		has_digit = 1'b0;
		seen_byte = 1'b0;
		utf8_left = '0;
		emitted = '0;
	endfunction

	function void emit(logic [7:0] b, logic lst);
		strip_result_t r;
		r.out_byte = b;
		r.text_end = 1'b0;
		r.out_length = '0;
		r.last = lst;
		awaited.push_back(r);
		if (emitted != '1)
			emitted++;
	endfunction

	function void ground_byte(logic [7:0] b);
		if (utf8_left != 0 && b[7:6] == 2'b10) begin
			utf8_left--;
			emit(b, 1'b1);
			return;
		end
		utf8_left = '0;
		if (b == tesu_pkg::CH_ESC) begin
			mode = tesu_pkg::MODE_ESC;
			return;
		end
		if ((b < tesu_pkg::CH_SPACE && b != tesu_pkg::CH_LF && b != tesu_pkg::CH_TAB) ||
			b == tesu_pkg::CH_DEL)
			return;
		// utf-8 lead bytes open a run of continuation bytes
		if (b >= 8'hC2 && b <= 8'hF4) begin
			utf8_left = (b <= 8'hDF) ? 2'd1 : (b <= 8'hEF) ? 2'd2 : 2'd3;
			emit(b, 1'b1);
			return;
		end
		if (b >= 8'h80 && b <= 8'h9F)
			return;
		emit(b, 1'b1);
	endfunction

	// predicts the items caused by one accepted text byte
	function void note_byte(logic [7:0] b);
		strip_result_t r;
		int n;
		int v;
		bytes_in++;
		if (b == tesu_pkg::CH_NUL) begin
			r.out_byte = 8'h00;
			r.text_end = 1'b1;
			r.out_length = emitted;
			r.last = 1'b1;
			awaited.push_back(r);
			if (emitted > longest)
				longest = emitted;
			texts++;
			clear_text();
			return;
		end
		case (mode)
			tesu_pkg::MODE_ESC: begin
				if (b == tesu_pkg::CH_LBRACK) begin
					mode = tesu_pkg::MODE_CSI;
					number = '0;
					has_digit = 1'b0;
					seen_byte = 1'b0;
				end else if (b == tesu_pkg::CH_RBRACK) begin
					mode = tesu_pkg::MODE_OSC;
				end else if (b >= tesu_pkg::CH_SPACE && b <= 8'h7E) begin
					mode = tesu_pkg::MODE_GROUND;
				end else begin
					mode = tesu_pkg::MODE_GROUND;
					ground_byte(b);
				end
			end
			tesu_pkg::MODE_CSI: begin
				if (b >= 8'h40 && b <= 8'h7E) begin
					if (b == tesu_pkg::CH_CUF && (has_digit || !seen_byte)) begin
						n = has_digit ? number : 1;
						if (n > cap)
							n = cap;
						if (n > tesu_pkg::SPACE_LIMIT)
							n = tesu_pkg::SPACE_LIMIT;
						if (n > 0)
							bursts++;
						for (int i = 0; i < n; i++)
							emit(tesu_pkg::CH_SPACE, i == n - 1);
					end
					mode = tesu_pkg::MODE_GROUND;
				end else begin
					seen_byte = 1'b1;
					if (b >= 8'h30 && b <= 8'h39) begin
						v = number * 10 + (b - 8'h30);
						number = (v > tesu_pkg::NUM_MAX) ? tesu_pkg::NUM_MAX : 4'(v);
						has_digit = 1'b1;
					end else if (b == tesu_pkg::CH_SEMI) begin
						has_digit = 1'b0;
					end
				end
			end
			tesu_pkg::MODE_OSC, tesu_pkg::MODE_OSC_ESC: begin
				if (mode == tesu_pkg::MODE_OSC_ESC && b == tesu_pkg::CH_BSLASH)
					mode = tesu_pkg::MODE_GROUND;
				else if (b == tesu_pkg::CH_BEL)
					mode = tesu_pkg::MODE_GROUND;
				else if (b == tesu_pkg::CH_ESC)
					mode = tesu_pkg::MODE_OSC_ESC;
				else
					mode = tesu_pkg::MODE_OSC;
			end
			default: begin
				mode = tesu_pkg::MODE_GROUND;
				ground_byte(b);
			end
		endcase
	endfunction

	task report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task check_result(input logic [7:0] b, input logic te, input logic [15:0] len,
			input logic lst);
		strip_result_t e;
		results_out++;
		if (awaited.size() == 0) begin
			report($sformatf("unexpected item byte %02h end %b length %0d", b, te, len));
			return;
		end
		e = awaited.pop_front();
		if (b !== e.out_byte)
			report($sformatf("out_byte %02h, expected %02h", b, e.out_byte));
		if (te !== e.text_end)
			report($sformatf("text_end %b, expected %b", te, e.text_end));
		if (len !== e.out_length)
			report($sformatf("out_length %0d, expected %0d", len, e.out_length));
		if (lst !== e.last)
			report($sformatf("last %b, expected %b", lst, e.last));
	endtask
endclass

module terminal_escape_stripper_unit_tb;
	localparam int STALL_LIMIT = 2000;
	localparam logic [tesu_pkg::ADDR_W-1:0] CAP_ADDR =
		tesu_pkg::ADDR_W'(4 * tesu_pkg::REG_CURSOR_RIGHT_CAP);
	localparam logic [7:0] OPENING [0:26] = '{
		8'h41, tesu_pkg::CH_TAB, tesu_pkg::CH_LF, 8'h01, tesu_pkg::CH_DEL,
		8'h85, 8'hFF, 8'hA0,
		8'hE2, 8'h82, 8'hAC,
		tesu_pkg::CH_ESC, 8'h63,
		tesu_pkg::CH_ESC, tesu_pkg::CH_LBRACK, 8'h31, tesu_pkg::CH_SEMI, 8'h32,
		tesu_pkg::CH_CUF,
		tesu_pkg::CH_ESC, tesu_pkg::CH_RBRACK, tesu_pkg::CH_ESC, 8'h61,
		tesu_pkg::CH_BEL,
		tesu_pkg::CH_ESC, 8'h01,
		tesu_pkg::CH_NUL
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [tesu_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [7:0]                  data_byte = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [7:0]                  out_byte;
	logic                        text_end;
	logic [15:0]                 out_length;
	logic                        last;

	stripped_text_checker sb = new();
	logic [7:0] text_bytes[$];
	bit         tx_calm;
	bit         rx_calm;
	int         cap_writes;
	int         quiet_cycles;

	terminal_escape_stripper_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.text_end(text_end), .out_length(out_length), .last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// input is noted before the result check so a fast path still lines up
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(data_byte);
			if (out_valid && out_ready)
				sb.check_result(out_byte, text_end, out_length, last);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stall before each item, with calm stretches
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
		end
	end

	task send_byte(input logic [7:0] b);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task send_text();
		while (text_bytes.size() != 0)
			send_byte(text_bytes.pop_front());
	endtask

	// drain every pending item, then give in-flight bytes time to clear the pipe
	task settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task write_cap(input logic [tesu_pkg::CAP_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[tesu_pkg::CAP_W-1:0] !== value)
			sb.report($sformatf("cap reads %0d, wrote %0d",
				prdata[tesu_pkg::CAP_W-1:0], value));
		psel <= 1'b0;
		penable <= 1'b0;
		sb.cap = value;
		cap_writes++;
	endtask

	function void add_number(int v);
		if (v >= 10)
			text_bytes.push_back(8'(8'h30 + v / 10));
		text_bytes.push_back(8'(8'h30 + v % 10));
	endfunction

	// mostly well-formed text and escape sequences, some broken ones and noise
	function void add_fragment();
		int kind;
		int need;
		int sel;
		logic [7:0] lead;
		kind = $urandom_range(0, 19);
		if (kind <= 4) begin
			repeat ($urandom_range(1, 6))
				text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
		end else if (kind <= 6) begin
			lead = 8'($urandom_range(8'hC2, 8'hF4));
			need = (lead <= 8'hDF) ? 1 : (lead <= 8'hEF) ? 2 : 3;
			text_bytes.push_back(lead);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(0, need - 1))
					text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
				text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else begin
				repeat (need)
					text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
		end else if (kind <= 10) begin
			text_bytes.push_back(tesu_pkg::CH_ESC);
			text_bytes.push_back(tesu_pkg::CH_LBRACK);
			sel = $urandom_range(0, 4);
			case (sel)
				1: add_number($urandom_range(0, 20));
				2: begin
					add_number($urandom_range(0, 9));
					text_bytes.push_back(tesu_pkg::CH_SEMI);
					add_number($urandom_range(0, 9));
				end
				3: begin
					text_bytes.push_back(8'h3F);
					if ($urandom_range(0, 1))
						add_number($urandom_range(0, 12));
				end
				4: begin
					add_number($urandom_range(0, 12));
					text_bytes.push_back(tesu_pkg::CH_SEMI);
				end
				default: ;
			endcase
			text_bytes.push_back(tesu_pkg::CH_CUF);
		end else if (kind <= 12) begin
			text_bytes.push_back(tesu_pkg::CH_ESC);
			text_bytes.push_back(tesu_pkg::CH_LBRACK);
			add_number($urandom_range(0, 99));
			text_bytes.push_back(tesu_pkg::CH_SEMI);
			add_number($urandom_range(0, 99));
			text_bytes.push_back(8'($urandom_range(8'h40, 8'h7E)));
		end else if (kind <= 14) begin
			text_bytes.push_back(tesu_pkg::CH_ESC);
			text_bytes.push_back(tesu_pkg::CH_RBRACK);
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 5) == 0)
					text_bytes.push_back(tesu_pkg::CH_ESC);
				text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end
			if ($urandom_range(0, 1)) begin
				text_bytes.push_back(tesu_pkg::CH_BEL);
			end else begin
				text_bytes.push_back(tesu_pkg::CH_ESC);
				text_bytes.push_back(tesu_pkg::CH_BSLASH);
			end
		end else if (kind == 15) begin
			text_bytes.push_back(tesu_pkg::CH_ESC);
			if ($urandom_range(0, 1))
				text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			else
				text_bytes.push_back(8'($urandom_range(1, 255)));
		end else if (kind <= 17) begin
			repeat ($urandom_range(1, 3))
				text_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			text_bytes.push_back(tesu_pkg::CH_NUL);
		end
	endfunction

	task run_random(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			add_fragment();
			sent += text_bytes.size();
			tx_calm = ($urandom_range(0, 3) == 0);
			send_text();
		end
	endtask

	initial begin
		int caps [0:6];
		caps = '{0, 15, 1, 4, 9, 8, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cap(tesu_pkg::CAP_RESET);
		foreach (OPENING[i])
			text_bytes.push_back(OPENING[i]);
		send_text();
		settle();

		for (int p = 0; p < 7; p++) begin
			write_cap(p == 6 ? 4'($urandom_range(0, 15)) : 4'(caps[p]));
			run_random(38);
			settle();
		end

		write_cap(4'($urandom_range(0, 15)));
		run_random(20);
		send_byte(tesu_pkg::CH_NUL);
		settle();
		repeat (10) @(posedge clk);

		if (sb.awaited.size() != 0)
			sb.report($sformatf("%0d items never arrived", sb.awaited.size()));
		$display("run covered %0d bytes over %0d texts, %0d items checked",
			sb.bytes_in, sb.texts, sb.results_out);
		$display("%0d cursor-right bursts, %0d cap writes, longest length reported %0d",
			sb.bursts, cap_writes, sb.longest);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
